// ----- rtl/core/wmf_pkg.sv -----
// shared constants and types for the window median filter
package wmf_pkg;

  localparam int DEF_MAX_RADIUS = 3;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam int PIX_W  = 8;
  localparam int RAD_W  = 2;
  localparam int WID_W  = 11;
  localparam int HGT_W  = 13;
  localparam int ROW_W  = 12;
  localparam int COL_W  = 10;

  typedef enum logic [1:0] {
    REG_RADIUS = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_index_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

endpackage

// ----- rtl/core/window_median_filter.sv -----
// top level of the streaming 2-d window median filter
//
// Pixels enter in raster order, one transaction each, and are written into a
// line store of 2*MAX_RADIUS+1 rows. Each pixel may complete a run of up to
// (r+1)^2 filtered outputs, delivered in raster order with last_of_run on the
// final one; a pixel that completes nothing passes through S_PLAN back to
// S_IDLE. Each output is found by a bit-serial rank search: for each of the
// 8 bits, MSB first, the window is swept one store read per cycle counting
// values below the trial prefix; n, the number of in-image window pixels, is
// at most (2r+1)^2. The store has a single read port. A write to the radius,
// width or height register restarts the frame at row 0, col 0.
module window_median_filter
  import wmf_pkg::*;
#(
  parameter int MAX_RADIUS = wmf_pkg::DEF_MAX_RADIUS,
  parameter int MAX_WIDTH  = wmf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = wmf_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [wmf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wmf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [wmf_pkg::PIX_W-1:0]      pixel_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [wmf_pkg::PIX_W-1:0]      median_value,
  output logic [wmf_pkg::ROW_W-1:0]      out_row,
  output logic [wmf_pkg::COL_W-1:0]      out_col,
  output logic                           last_of_run
);

  localparam int STORE_ROWS = 2 * MAX_RADIUS + 1;
  localparam int SLOT_W     = $clog2(STORE_ROWS + 1);
  localparam int XC_W       = $clog2(MAX_WIDTH);
  localparam int DEPTH      = STORE_ROWS * MAX_WIDTH;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int R_W        = $clog2(MAX_HEIGHT) + 1;
  localparam int C_W        = $clog2(MAX_WIDTH) + 1;
  localparam int MR_W       = $clog2(MAX_RADIUS + 1);
  localparam int CNT_W      = $clog2(STORE_ROWS * STORE_ROWS + 1);
  localparam int HW         = $clog2(MAX_HEIGHT + 1);
  localparam int WW         = $clog2(MAX_WIDTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_PLAN, S_INIT, S_SCAN, S_BIT, S_OUT
  } state_t;

  state_t state;

  logic [RAD_W-1:0] window_radius;
  logic [WID_W-1:0] image_width;
  logic [HGT_W-1:0] image_height;

  logic [PIX_W-1:0] store [DEPTH];
  logic [PIX_W-1:0] rd_data;
  logic [ADDR_W-1:0] rd_addr;

  logic [R_W-1:0] in_row;
  logic [C_W-1:0] in_col;

  // effective register values
  logic [MR_W-1:0] r_eff;
  logic [HW-1:0]   h_eff;
  logic [WW-1:0]   w_eff;

  always_comb begin
    if ({{(32-RAD_W){1'b0}}, window_radius} > MAX_RADIUS) r_eff = MR_W'(MAX_RADIUS);
    else r_eff = MR_W'(window_radius);
    if (image_height == '0) h_eff = HW'(1);
    else if ({{(32-HGT_W){1'b0}}, image_height} > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
    else h_eff = HW'(image_height);
    if (image_width == '0) w_eff = WW'(1);
    else if ({{(32-WID_W){1'b0}}, image_width} > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(image_width);
  end

  // run bounds and loop positions, signed for border clipping
  logic signed [R_W+1:0] x0, x1, x, i, i0, i1;
  logic signed [C_W+1:0] y0, y1, y, j, j0, j1;
  logic [SLOT_W-1:0] slot;
  logic [CNT_W-1:0]  n, below;
  logic [PIX_W-1:0]  prefix;
  logic [$clog2(PIX_W)-1:0] bitn;
  logic              rd_pending;

  logic [PIX_W-1:0]  trial;
  assign trial = prefix | (PIX_W'(1) << bitn);

  logic signed [R_W+1:0] hm1, rr;
  logic signed [C_W+1:0] wm1, rc;
  assign hm1 = (R_W+2)'(h_eff) - (R_W+2)'(1);
  assign wm1 = (C_W+2)'(w_eff) - (C_W+2)'(1);
  assign rr  = (R_W+2)'(r_eff);
  assign rc  = (C_W+2)'(r_eff);

  // row and store slot of the pixel that started the current run
  logic signed [R_W+1:0] run_row;
  logic [SLOT_W-1:0]     run_slot;

  // top window row of output x and its slot, at most 2r rows above run_row
  logic signed [R_W+1:0] win_top, top_gap;
  logic [SLOT_W:0]       top_slot;
  always_comb begin
    win_top = (x >= rr) ? x - rr : '0;
    top_gap = run_row - win_top;
    top_slot = {1'b0, run_slot} + (SLOT_W+1)'(STORE_ROWS)
               - (SLOT_W+1)'(top_gap[SLOT_W-1:0]);
    if (top_slot >= (SLOT_W+1)'(STORE_ROWS)) top_slot = top_slot - (SLOT_W+1)'(STORE_ROWS);
  end

  assign in_stall = rst || (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall)
      store[ADDR_W'(slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(in_col[XC_W-1:0])] <= pixel_value;
    rd_data <= store[rd_addr];
  end

  // store address of window position (i,j); i mod store rows kept incrementally
  logic [SLOT_W-1:0] islot;
  always_comb begin
    rd_addr = ADDR_W'(islot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(j[XC_W-1:0]);
  end

  logic [SLOT_W-1:0] i0slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      window_radius <= RAD_W'(1);
      image_width <= WID_W'(640);
      image_height <= HGT_W'(480);
      in_row <= '0;
      in_col <= '0;
      slot <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write && cfg_index <= CFG_IDX_W'(REG_HEIGHT)) begin
        case (cfg_index)
          REG_RADIUS: window_radius <= cfg_data[RAD_W-1:0];
          REG_WIDTH:  image_width <= cfg_data[WID_W-1:0];
          REG_HEIGHT: image_height <= cfg_data[HGT_W-1:0];
          default: ;
        endcase
        in_row <= '0;
        in_col <= '0;
        slot <= '0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            run_row <= (R_W+2)'(in_row);
            run_slot <= slot;
            if (((R_W+2)'(in_row) + 1 < (R_W+2)'(h_eff) && (R_W+2)'(in_row) < rr) ||
                ((C_W+2)'(in_col) + 1 < (C_W+2)'(w_eff) && (C_W+2)'(in_col) < rc)) begin
              x0 <= (R_W+2)'(1);
              x1 <= '0;
            end else if ((R_W+2)'(in_row) + 1 >= (R_W+2)'(h_eff)) begin
              x0 <= (hm1 >= rr) ? hm1 - rr : '0;
              x1 <= hm1;
            end else begin
              x0 <= (R_W+2)'(in_row) - rr;
              x1 <= (R_W+2)'(in_row) - rr;
            end
            if ((C_W+2)'(in_col) + 1 >= (C_W+2)'(w_eff)) begin
              y0 <= (wm1 >= rc) ? wm1 - rc : '0;
              y1 <= wm1;
            end else begin
              y0 <= (C_W+2)'(in_col) - rc;
              y1 <= (C_W+2)'(in_col) - rc;
            end
            // advance input position
            if ((C_W+2)'(in_col) + 1 >= (C_W+2)'(w_eff)) begin
              in_col <= '0;
              if ((R_W+2)'(in_row) + 1 >= (R_W+2)'(h_eff)) begin
                in_row <= '0;
                slot <= '0;
              end else begin
                in_row <= in_row + 1'b1;
                slot <= (slot == SLOT_W'(STORE_ROWS - 1)) ? '0 : slot + 1'b1;
              end
            end else begin
              in_col <= in_col + 1'b1;
            end
            state <= S_PLAN;
          end
        end
        S_PLAN: begin
          x <= x0;
          y <= y0;
          if (x0 > x1) state <= S_IDLE;
          else state <= S_INIT;
        end
        S_INIT: begin
          // clip window for output (x,y)
          i0 <= win_top;
          i1 <= (x + rr <= hm1) ? x + rr : hm1;
          j0 <= (y >= rc) ? y - rc : '0;
          j1 <= (y + rc <= wm1) ? y + rc : wm1;
          i  <= win_top;
          j  <= (y >= rc) ? y - rc : '0;
          i0slot <= top_slot[SLOT_W-1:0];
          islot  <= top_slot[SLOT_W-1:0];
          prefix <= '0;
          bitn <= ($clog2(PIX_W))'(PIX_W - 1);
          below <= '0;
          n <= '0;
          rd_pending <= 1'b0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          // one read issued per cycle, its data compared in the following cycle
          if (rd_pending && rd_data < trial) below <= below + 1'b1;
          if (rd_pending && bitn == ($clog2(PIX_W))'(PIX_W - 1)) n <= n + 1'b1;
          if (i > i1) begin
            rd_pending <= 1'b0;
            if (!rd_pending) state <= S_BIT;
          end else begin
            rd_pending <= 1'b1;
            if (j == j1) begin
              j <= j0;
              i <= i + (R_W+2)'(1);
              islot <= (islot == SLOT_W'(STORE_ROWS - 1)) ? '0 : islot + 1'b1;
            end else begin
              j <= j + (C_W+2)'(1);
            end
          end
        end
        S_BIT: begin
          // the median bit is set when at most n/2 values lie below the trial
          if (below <= (n >> 1)) prefix <= trial;
          below <= '0;
          i <= i0;
          j <= j0;
          islot <= i0slot;
          if (bitn == '0) begin
            state <= S_OUT;
            median_value <= (below <= (n >> 1)) ? trial : prefix;
            out_row <= ROW_W'(x);
            out_col <= COL_W'(y);
            last_of_run <= (x == x1) && (y == y1);
            out_valid <= 1'b1;
          end else begin
            bitn <= bitn - 1'b1;
            state <= S_SCAN;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (y == y1) begin
              y <= y0;
              x <= x + (R_W+2)'(1);
              state <= (x == x1) ? S_IDLE : S_INIT;
            end else begin
              y <= y + (C_W+2)'(1);
              state <= S_INIT;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
